// ===== hw/rtl/pfcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pfcs_pkg: shared types and constants for the pose frame serializer
// Frame layout indexes, CRC-16/ARC byte update and CRC adjustment.
// ----------------------------------------------------------------------------
package pfcs_pkg;

  localparam int WordBits      = 32;
  localparam int PayloadBits   = 3 * WordBits;
  localparam int ByteBits      = 8;
  localparam int IdxBits       = 4;
  localparam int QueueDepth    = 2;
  localparam int QueuePtrBits  = 1;
  localparam int QueueCntBits  = 2;

  localparam logic [IdxBits-1:0] PayloadBytes = 4'd12;
  localparam logic [IdxBits-1:0] CrcLoIdx     = 4'd12;
  localparam logic [IdxBits-1:0] CrcHiIdx     = 4'd13;
  localparam logic [IdxBits-1:0] LastIdx      = 4'd14;

  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef struct packed {
    logic                    valid;
    logic [QueueCntBits-1:0] level;
    logic [PayloadBits-1:0]  data;
  } q_head_t;

  typedef struct packed {
    logic               busy;
    logic [IdxBits-1:0] idx;
  } back_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [ByteBits-1:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_adjust(input logic [15:0] crc_in);
    logic [15:0] c;
    c = crc_in;
    if (c[15:8] == 8'h00) begin
      c[8] = 1'b1;
    end
    if (c[7:0] == 8'h00) begin
      c[0] = 1'b1;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/pfcs_front.sv =====
// ----------------------------------------------------------------------------
// pfcs_front: input stage and payload queue
// Accepts pose payloads from the input stream into a two-entry queue.
// ----------------------------------------------------------------------------
module pfcs_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pfcs_pkg::PayloadBits-1:0] s_axis_tdata,
  output pfcs_pkg::q_head_t                head,
  input  logic                             head_pop
);

  logic [pfcs_pkg::PayloadBits-1:0]  entries [pfcs_pkg::QueueDepth];
  logic [pfcs_pkg::QueuePtrBits-1:0] wr_ptr;
  logic [pfcs_pkg::QueuePtrBits-1:0] rd_ptr;
  logic [pfcs_pkg::QueueCntBits-1:0] count;
  logic                              push;
  logic                              pop;

  assign s_axis_tready = (count != pfcs_pkg::QueueCntBits'(pfcs_pkg::QueueDepth));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = head_pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.level = count;
  assign head.data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pfcs_back.sv =====
// ----------------------------------------------------------------------------
// pfcs_back: frame serializer
// Emits the payload bytes, the adjusted CRC-16/ARC and the terminator.
// ----------------------------------------------------------------------------
module pfcs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  pfcs_pkg::q_head_t             head,
  output logic                          head_pop,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pfcs_pkg::ByteBits-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  output pfcs_pkg::back_stat_t          stat
);

  logic [pfcs_pkg::PayloadBits-1:0] payload;
  logic [15:0]                      crc;
  logic [15:0]                      crc_adj;
  logic [pfcs_pkg::IdxBits-1:0]     idx;
  logic                             busy;
  logic                             out_valid;
  logic [pfcs_pkg::ByteBits-1:0]    out_byte;
  logic                             out_last;
  logic                             advance;

  always_comb begin
    advance  = !out_valid || m_axis_tready;
    head_pop = advance && head.valid && (!busy || idx == pfcs_pkg::LastIdx);
    crc_adj  = pfcs_pkg::crc_adjust(crc);
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tlast  = out_last;
  assign stat.busy     = busy;
  assign stat.idx      = idx;

  always_ff @(posedge clk) begin
    if (advance && busy) begin
      if (idx < pfcs_pkg::PayloadBytes) begin
        out_byte <= payload[pfcs_pkg::ByteBits-1:0];
        out_last <= 1'b0;
        payload  <= payload >> pfcs_pkg::ByteBits;
        crc      <= pfcs_pkg::crc_byte(crc, payload[pfcs_pkg::ByteBits-1:0]);
      end else if (idx == pfcs_pkg::CrcLoIdx) begin
        out_byte <= crc_adj[7:0];
        out_last <= 1'b0;
      end else if (idx == pfcs_pkg::CrcHiIdx) begin
        out_byte <= crc_adj[15:8];
        out_last <= 1'b0;
      end else begin
        out_byte <= '0;
        out_last <= 1'b1;
      end
    end
    if (head_pop) begin
      payload <= head.data;
      crc     <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= busy;
      if (head_pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        if (idx == pfcs_pkg::LastIdx) begin
          busy <= 1'b0;
          idx  <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/pose_frame_crc16_serializer.sv =====
// ----------------------------------------------------------------------------
// pose_frame_crc16_serializer: pose payload to CRC-protected byte frame
//
// Input stream: one transfer carries x, y and rotation words (96 bits).
// Output stream: 15 byte transfers per input: the 12 payload bytes, each
// word least significant byte first, then the CRC-16/ARC of those bytes
// (adjusted so neither byte is zero) low byte first, then a zero byte
// flagged by tlast.
// When the serializer is idle, the first byte of a frame passes from its
// queue entry through the payload register to the output register.
// Throughput: one byte per cycle on the output register while the
// receiver does not stall; the CRC is updated as each payload byte goes out.
// A two-entry queue sits between the input and the serializer, so up to
// two payloads are taken while a frame is still going out.
// Reset empties the queue and drops any frame in progress.
// When the receiver stalls, the output byte holds and the serializer waits;
// the input keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
module pose_frame_crc16_serializer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // x_bits[31:0], y_bits[63:32], rz_bits[95:64]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // frame_byte[7:0]
  output logic        m_axis_tlast
);

  pfcs_pkg::q_head_t    head;
  logic                 head_pop;
  pfcs_pkg::back_stat_t stat;

  pfcs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .head          (head),
    .head_pop      (head_pop)
  );

  pfcs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_pop      (head_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .stat          (stat)
  );

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    stat.idx <= pfcs_pkg::LastIdx)
    else $error("frame byte index out of range");

  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'h00)
    else $error("terminator byte not zero");

  a_queue_level: assert property (@(posedge clk) disable iff (rst)
    head.level <= 2'(pfcs_pkg::QueueDepth))
    else $error("queue overfilled");

  a_pop_when_idle_or_last: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> !stat.busy || stat.idx == pfcs_pkg::LastIdx)
    else $error("payload popped mid-frame");

endmodule
